### hdl/gcm_pkg.sv
`timescale 1ns / 1ps

package gcm_pkg;

	// Number of hand positions kept for averaging and for the scroll delta.
	localparam int HISTORY_DEPTH = 3;
	localparam int HIST_LOG      = $clog2(HISTORY_DEPTH);

	// Field widths.
	localparam int POS_W   = 16;
	localparam int GAIN_W  = 12;
	localparam int FRAC_W  = 13;
	localparam int PADDR_W = 5;

	// Datapath widths: sum of the history, multiplier operand, product,
	// numerator with offset, and the quotient before the final divide.
	localparam int SUM_W   = POS_W + HIST_LOG;
	localparam int OPA_W   = SUM_W + 1;
	localparam int P_W     = OPA_W + GAIN_W + 1;
	localparam int NUM_W   = P_W + 1;
	localparam int TRAW_W  = NUM_W + 1 - FRAC_W;
	localparam int T_W     = 16 + HIST_LOG;
	localparam int Q_W     = 17;

	// Rounding offsets for the scroll and cursor paths.
	localparam int HALF_SCROLL = 4096;
	localparam int HALF_CURSOR = 4096 * HISTORY_DEPTH;

	// Magnitudes at or above these saturate anyway, so they clamp early.
	localparam int T_MAX      = 32768 * HISTORY_DEPTH;
	localparam int SCROLL_MAX = 32768;

	// Exact floor division by HISTORY_DEPTH through a reciprocal multiply.
	localparam int DIV_SHIFT = T_W + HIST_LOG;
	localparam int M_W       = T_W + 1;
	localparam longint unsigned DIV_MULT =
		((64'd1 << DIV_SHIFT) + HISTORY_DEPTH - 1) / HISTORY_DEPTH;
	localparam int QP_W = T_W + M_W;

	// Register map, by word index.
	localparam logic [2:0] REG_LEFT_LEVEL  = 3'd0;
	localparam logic [2:0] REG_RIGHT_LEVEL = 3'd1;
	localparam logic [2:0] REG_CURSOR_GAIN = 3'd2;
	localparam logic [2:0] REG_CURSOR_XOFS = 3'd3;
	localparam logic [2:0] REG_CURSOR_YOFS = 3'd4;
	localparam logic [2:0] REG_SCROLL_GAIN = 3'd5;

	// Pointer event codes.
	typedef enum logic [2:0] {
		EV_MOVE          = 3'd0,
		EV_LEFT_PRESS    = 3'd1,
		EV_LEFT_RELEASE  = 3'd2,
		EV_RIGHT_PRESS   = 3'd3,
		EV_RIGHT_RELEASE = 3'd4,
		EV_SCROLL        = 3'd5
	} evt_kind_t;

	// Apply a sign to a magnitude and saturate to 16 bits.
	function automatic logic signed [15:0] sat_signed(input logic neg,
			input logic [Q_W-1:0] mag);
		logic signed [15:0] res;
		if (neg) begin
			if (mag >= Q_W'(32768)) begin
				res = 16'sh8000;
			end else begin
				res = -$signed(mag[15:0]);
			end
		end else begin
			if (mag > Q_W'(32767)) begin
				res = 16'sh7fff;
			end else begin
				res = $signed(mag[15:0]);
			end
		end
		return res;
	endfunction

endpackage

### hdl/gcm_if.sv
`timescale 1ns / 1ps

// One hand sample per request.
interface gcm_hand_if;
	logic               valid;
	logic               ready;
	logic signed [15:0] pos_x;
	logic signed [15:0] pos_y;
	logic signed [15:0] normal_x;
	logic signed [15:0] normal_y;
	logic               open_hand;

	modport source (output valid, pos_x, pos_y, normal_x, normal_y, open_hand,
		input ready);
	modport sink (input valid, pos_x, pos_y, normal_x, normal_y, open_hand,
		output ready);
endinterface

// One pointer event per request.
interface gcm_ptr_if;
	logic               valid;
	logic               ready;
	logic [2:0]         event_kind;
	logic signed [15:0] cursor_x;
	logic signed [15:0] cursor_y;
	logic signed [15:0] scroll_x;
	logic signed [15:0] scroll_y;

	modport source (output valid, event_kind, cursor_x, cursor_y, scroll_x, scroll_y,
		input ready);
	modport sink (input valid, event_kind, cursor_x, cursor_y, scroll_x, scroll_y,
		output ready);
endinterface

### hdl/gesture_cursor_mapper.sv
`timescale 1ns / 1ps

// Gesture cursor mapper: turns each hand sample into one pointer event. The
// block accepts one sample per clock cycle while the output is not stalled.
// Each request passes through four register stages (operands with the
// history and button update, gain multiply, offset and rounding, reciprocal
// divide and saturation), the first of which loads at the accepting edge.
// Each stage holds its request while the output is stalled, so up to four
// requests may be in flight. An open hand yields a scroll event from the
// oldest minus the newest of the last HISTORY_DEPTH positions; otherwise the
// mean position becomes a cursor position and the left/right button machine
// reports a press, a release or a plain move. The user must write registers
// over the APB port only while no request is in flight; the block itself
// does not enforce this.
module gesture_cursor_mapper
	import gcm_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	gcm_hand_if.sink            hand,
	gcm_ptr_if.source           pointer,
	input  logic                psel,
	input  logic                penable,
	input  logic                pwrite,
	input  logic [PADDR_W-1:0]  paddr,
	input  logic [31:0]         pwdata,
	output logic [31:0]         prdata,
	output logic                pready
);

	// Configuration registers.
	logic signed [15:0]  left_level_q;
	logic signed [15:0]  right_level_q;
	logic [GAIN_W-1:0]   cursor_gain_q;
	logic [GAIN_W-1:0]   cursor_xofs_q;
	logic [GAIN_W-1:0]   cursor_yofs_q;
	logic [GAIN_W-1:0]   scroll_gain_q;
	logic                cfg_wr;

	// History line of the previous samples, newest at index zero, and button
	// state. The incoming sample completes the ring of HISTORY_DEPTH entries.
	logic signed [POS_W-1:0] hist_x_q [HISTORY_DEPTH-2:0];
	logic signed [POS_W-1:0] hist_y_q [HISTORY_DEPTH-2:0];
	logic                    left_down_q;
	logic                    right_down_q;

	// Stage valids and per-stage ready.
	logic v_s1, v_s2, v_s3, out_v_q;
	logic rdy_s1, rdy_s2, rdy_s3, rdy_o;
	logic accept;

	// Accept-side logic.
	logic signed [SUM_W-1:0] sum_x, sum_y;
	logic signed [OPA_W-1:0] dx, dy;
	logic                    lt_left, lt_right;
	evt_kind_t               kind_in;
	logic                    left_next, right_next;

	// Stage 1: multiplier operands.
	logic signed [OPA_W-1:0] opa_x_s1, opa_y_s1;
	logic                    open_s1;
	evt_kind_t               kind_s1;

	// Stage 2: products.
	logic signed [P_W-1:0]   prod_x_s2, prod_y_s2;
	logic                    open_s2;
	evt_kind_t               kind_s2;

	// Stage 3: rounded magnitudes before the final divide.
	logic signed [NUM_W-1:0] num_x, num_y;
	logic [NUM_W-1:0]        ofs_x, ofs_y;
	logic [NUM_W-1:0]        mag_x, mag_y;
	logic [NUM_W:0]          rnd_x, rnd_y;
	logic [TRAW_W-1:0]       traw_x, traw_y;
	logic [NUM_W:0]          half;
	logic [T_W-1:0]          t_x, t_y;
	logic [T_W-1:0]          t_x_s3, t_y_s3;
	logic                    neg_x_s3, neg_y_s3;
	logic                    open_s3;
	evt_kind_t               kind_s3;

	// Output stage.
	logic [QP_W-1:0]         qp_x, qp_y;
	logic [Q_W-1:0]          q_x, q_y;
	logic signed [15:0]      res_x, res_y;
	evt_kind_t               kind_q;
	logic signed [15:0]      cursor_x_q, cursor_y_q, scroll_x_q, scroll_y_q;

	// APB register port.
	assign pready = 1'b1;
	assign cfg_wr = psel & penable & pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			left_level_q  <= -16'sd7373;
			right_level_q <= -16'sd8192;
			cursor_gain_q <= GAIN_W'(1280);
			cursor_xofs_q <= GAIN_W'(640);
			cursor_yofs_q <= GAIN_W'(400);
			scroll_gain_q <= GAIN_W'(600);
		end else if (cfg_wr) begin
			case (paddr[4:2])
				REG_LEFT_LEVEL:  left_level_q  <= $signed(pwdata[15:0]);
				REG_RIGHT_LEVEL: right_level_q <= $signed(pwdata[15:0]);
				REG_CURSOR_GAIN: cursor_gain_q <= pwdata[GAIN_W-1:0];
				REG_CURSOR_XOFS: cursor_xofs_q <= pwdata[GAIN_W-1:0];
				REG_CURSOR_YOFS: cursor_yofs_q <= pwdata[GAIN_W-1:0];
				REG_SCROLL_GAIN: scroll_gain_q <= pwdata[GAIN_W-1:0];
				default: ;
			endcase
		end
	end

	// Register read back.
	always_comb begin
		case (paddr[4:2])
			REG_LEFT_LEVEL:  prdata = 32'(left_level_q);
			REG_RIGHT_LEVEL: prdata = 32'(right_level_q);
			REG_CURSOR_GAIN: prdata = 32'(cursor_gain_q);
			REG_CURSOR_XOFS: prdata = 32'(cursor_xofs_q);
			REG_CURSOR_YOFS: prdata = 32'(cursor_yofs_q);
			REG_SCROLL_GAIN: prdata = 32'(scroll_gain_q);
			default:         prdata = 32'd0;
		endcase
	end

	// Pipeline flow: a stage loads when it is empty or its successor moves.
	assign rdy_o      = !out_v_q || pointer.ready;
	assign rdy_s3     = !v_s3 || rdy_o;
	assign rdy_s2     = !v_s2 || rdy_s3;
	assign rdy_s1     = !v_s1 || rdy_s2;
	assign hand.ready = rdy_s1;
	assign accept     = hand.valid && rdy_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1    <= 1'b0;
			v_s2    <= 1'b0;
			v_s3    <= 1'b0;
			out_v_q <= 1'b0;
		end else begin
			if (rdy_s1) begin
				v_s1 <= hand.valid;
			end
			if (rdy_s2) begin
				v_s2 <= v_s1;
			end
			if (rdy_s3) begin
				v_s3 <= v_s2;
			end
			if (rdy_o) begin
				out_v_q <= v_s3;
			end
		end
	end

	// History sums including the new sample, and the oldest-minus-newest delta.
	always_comb begin
		sum_x = SUM_W'(hand.pos_x);
		sum_y = SUM_W'(hand.pos_y);
		for (int i = 0; i < HISTORY_DEPTH - 1; i++) begin
			sum_x = sum_x + SUM_W'(hist_x_q[i]);
			sum_y = sum_y + SUM_W'(hist_y_q[i]);
		end
		dx = OPA_W'(hist_x_q[HISTORY_DEPTH-2]) - OPA_W'(hand.pos_x);
		dy = OPA_W'(hist_y_q[HISTORY_DEPTH-2]) - OPA_W'(hand.pos_y);
	end

	// Prioritized button machine; a scroll leaves the buttons alone.
	always_comb begin
		lt_left    = hand.normal_y < left_level_q;
		lt_right   = hand.normal_x < right_level_q;
		left_next  = left_down_q;
		right_next = right_down_q;
		if (hand.open_hand) begin
			kind_in = EV_SCROLL;
		end else if (!left_down_q && lt_left) begin
			kind_in   = EV_LEFT_PRESS;
			left_next = 1'b1;
		end else if (left_down_q && !lt_left) begin
			kind_in   = EV_LEFT_RELEASE;
			left_next = 1'b0;
		end else if (!right_down_q && lt_right) begin
			kind_in    = EV_RIGHT_PRESS;
			right_next = 1'b1;
		end else if (right_down_q && !lt_right) begin
			kind_in    = EV_RIGHT_RELEASE;
			right_next = 1'b0;
		end else begin
			kind_in = EV_MOVE;
		end
	end

	// History line and button state advance on each accepted request.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < HISTORY_DEPTH - 1; i++) begin
				hist_x_q[i] <= '0;
				hist_y_q[i] <= '0;
			end
			left_down_q  <= 1'b0;
			right_down_q <= 1'b0;
		end else if (accept) begin
			hist_x_q[0] <= hand.pos_x;
			hist_y_q[0] <= hand.pos_y;
			for (int i = 1; i < HISTORY_DEPTH - 1; i++) begin
				hist_x_q[i] <= hist_x_q[i-1];
				hist_y_q[i] <= hist_y_q[i-1];
			end
			left_down_q  <= left_next;
			right_down_q <= right_next;
		end
	end

	// Stage 1: operands. X is negated on both paths; negating before the
	// symmetric rounding equals negating after it.
	always_ff @(posedge clk) begin
		if (rdy_s1) begin
			open_s1  <= hand.open_hand;
			kind_s1  <= kind_in;
			opa_x_s1 <= hand.open_hand ? -dx : -OPA_W'(sum_x);
			opa_y_s1 <= hand.open_hand ? dy : OPA_W'(sum_y);
		end
	end

	// Stage 2: gain multiply, shared between scroll and cursor.
	always_ff @(posedge clk) begin
		if (rdy_s2) begin
			open_s2   <= open_s1;
			kind_s2   <= kind_s1;
			prod_x_s2 <= P_W'(opa_x_s1) * P_W'($signed({1'b0,
				open_s1 ? scroll_gain_q : cursor_gain_q}));
			prod_y_s2 <= P_W'(opa_y_s1) * P_W'($signed({1'b0,
				open_s1 ? scroll_gain_q : cursor_gain_q}));
		end
	end

	// Stage 3: add the scaled offset, round half away from zero, drop the
	// fraction and clamp values that saturate anyway.
	always_comb begin
		ofs_x  = open_s2 ? '0 :
			(NUM_W'(cursor_xofs_q) * NUM_W'(HISTORY_DEPTH)) << FRAC_W;
		ofs_y  = open_s2 ? '0 :
			(NUM_W'(cursor_yofs_q) * NUM_W'(HISTORY_DEPTH)) << FRAC_W;
		num_x  = NUM_W'(prod_x_s2) + $signed(ofs_x);
		num_y  = NUM_W'(prod_y_s2) + $signed(ofs_y);
		mag_x  = num_x[NUM_W-1] ? NUM_W'(-num_x) : NUM_W'(num_x);
		mag_y  = num_y[NUM_W-1] ? NUM_W'(-num_y) : NUM_W'(num_y);
		half   = open_s2 ? (NUM_W+1)'(HALF_SCROLL) : (NUM_W+1)'(HALF_CURSOR);
		rnd_x  = (NUM_W+1)'(mag_x) + half;
		rnd_y  = (NUM_W+1)'(mag_y) + half;
		traw_x = rnd_x[NUM_W:FRAC_W];
		traw_y = rnd_y[NUM_W:FRAC_W];
		t_x    = (traw_x > TRAW_W'(T_MAX)) ? T_W'(T_MAX) : T_W'(traw_x);
		t_y    = (traw_y > TRAW_W'(T_MAX)) ? T_W'(T_MAX) : T_W'(traw_y);
	end

	always_ff @(posedge clk) begin
		if (rdy_s3) begin
			open_s3  <= open_s2;
			kind_s3  <= kind_s2;
			neg_x_s3 <= num_x[NUM_W-1];
			neg_y_s3 <= num_y[NUM_W-1];
			t_x_s3   <= t_x;
			t_y_s3   <= t_y;
		end
	end

	// Output stage: the cursor path divides by the history depth through a
	// reciprocal multiply; both paths then saturate to 16 bits.
	always_comb begin
		qp_x = QP_W'(t_x_s3) * QP_W'(DIV_MULT);
		qp_y = QP_W'(t_y_s3) * QP_W'(DIV_MULT);
		if (open_s3) begin
			q_x = (t_x_s3 > T_W'(SCROLL_MAX)) ? Q_W'(SCROLL_MAX) : Q_W'(t_x_s3);
			q_y = (t_y_s3 > T_W'(SCROLL_MAX)) ? Q_W'(SCROLL_MAX) : Q_W'(t_y_s3);
		end else begin
			q_x = qp_x[DIV_SHIFT +: Q_W];
			q_y = qp_y[DIV_SHIFT +: Q_W];
		end
		res_x = sat_signed(neg_x_s3, q_x);
		res_y = sat_signed(neg_y_s3, q_y);
	end

	always_ff @(posedge clk) begin
		if (rdy_o) begin
			kind_q     <= kind_s3;
			cursor_x_q <= open_s3 ? 16'sd0 : res_x;
			cursor_y_q <= open_s3 ? 16'sd0 : res_y;
			scroll_x_q <= open_s3 ? res_x : 16'sd0;
			scroll_y_q <= open_s3 ? res_y : 16'sd0;
		end
	end

	assign pointer.valid      = out_v_q;
	assign pointer.event_kind = kind_q;
	assign pointer.cursor_x   = cursor_x_q;
	assign pointer.cursor_y   = cursor_y_q;
	assign pointer.scroll_x   = scroll_x_q;
	assign pointer.scroll_y   = scroll_y_q;

endmodule
